// ===== hdl/websocket_frame_decoder_defines.svh =====
// assertion macros of the frame decoder, used by the parser module
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define WSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wsfd_pkg.sv =====
// types and constants of the websocket frame decoder
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_OPCODE = 2'd2,
    ST_SHORT  = 2'd3
  } status_e;

  localparam logic [3:0] OPCODE_MASK = 4'hF;
  localparam logic [3:0] OPCODE_TEXT = 4'h1;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [2:0] EXT16_LEFT  = 3'd1;
  localparam logic [2:0] EXT64_LEFT  = 3'd7;
  localparam logic [1:0] KEY_LAST    = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    status_e     status;
    logic        msg_end;
  } result_t;

endpackage

// ===== hdl/wsfd_parser.sv =====
// frame header parser, length and key capture, payload unmasking
module wsfd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              buffer_end_i,
  output wsfd_pkg::result_t result_o
);

  `include "websocket_frame_decoder_defines.svh"

  wsfd_pkg::phase_e phase_q, phase_d;
  logic [63:0] payload_length_q, payload_length_d;
  logic [2:0]  length_bytes_left_q, length_bytes_left_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [1:0]  key_bytes_seen_q, key_bytes_seen_d;
  logic [63:0] payload_remaining_q, payload_remaining_d;
  logic [1:0]  mask_position_q, mask_position_d;

  logic [6:0]  len7;
  logic [63:0] remaining_dec;
  logic        remaining_done;
  logic [7:0]  key_byte;
  wsfd_pkg::phase_e after_phase;

  assign len7           = data_byte_i[6:0];
  assign remaining_dec  = payload_remaining_q - 64'd1;
  assign remaining_done = (remaining_dec == '0);
  assign after_phase    = buffer_end_i ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_SKIP;

  // key byte 0 sits in the top bits
  always_comb begin
    case (mask_position_q)
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_d             = phase_q;
    payload_length_d    = payload_length_q;
    length_bytes_left_d = length_bytes_left_q;
    mask_key_d          = mask_key_q;
    key_bytes_seen_d    = key_bytes_seen_q;
    payload_remaining_d = payload_remaining_q;
    mask_position_d     = mask_position_q;
    case (phase_q)
      wsfd_pkg::PH_HDR1: begin
        if (buffer_end_i) begin
          phase_d = wsfd_pkg::PH_HDR1;
        end else if ((data_byte_i[3:0] & wsfd_pkg::OPCODE_MASK) != wsfd_pkg::OPCODE_TEXT) begin
          phase_d = wsfd_pkg::PH_SKIP;
        end else begin
          phase_d = wsfd_pkg::PH_HDR2;
        end
      end
      wsfd_pkg::PH_HDR2: begin
        payload_length_d = '0;
        key_bytes_seen_d = '0;
        mask_key_d       = '0;
        if (len7 == wsfd_pkg::LEN_EXT16) begin
          length_bytes_left_d = wsfd_pkg::EXT16_LEFT;
          phase_d             = wsfd_pkg::PH_EXTLEN;
        end else if (len7 == wsfd_pkg::LEN_EXT64) begin
          length_bytes_left_d = wsfd_pkg::EXT64_LEFT;
          phase_d             = wsfd_pkg::PH_EXTLEN;
        end else begin
          payload_length_d = {57'd0, len7};
          phase_d          = wsfd_pkg::PH_KEY;
        end
        if (buffer_end_i) phase_d = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_EXTLEN: begin
        payload_length_d = {payload_length_q[55:0], data_byte_i};
        if (length_bytes_left_q == '0) begin
          key_bytes_seen_d = '0;
          mask_key_d       = '0;
          phase_d          = wsfd_pkg::PH_KEY;
        end else begin
          length_bytes_left_d = length_bytes_left_q - 3'd1;
        end
        if (buffer_end_i) phase_d = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_KEY: begin
        mask_key_d = {mask_key_q[23:0], data_byte_i};
        if (key_bytes_seen_q == wsfd_pkg::KEY_LAST) begin
          key_bytes_seen_d    = '0;
          payload_remaining_d = payload_length_q;
          mask_position_d     = '0;
          if (payload_length_q == '0) begin
            phase_d = after_phase;
          end else if (buffer_end_i) begin
            phase_d = wsfd_pkg::PH_HDR1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end else begin
          key_bytes_seen_d = key_bytes_seen_q + 2'd1;
          if (buffer_end_i) phase_d = wsfd_pkg::PH_HDR1;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        payload_remaining_d = remaining_dec;
        mask_position_d     = mask_position_q + 2'd1;
        if (remaining_done) begin
          phase_d = after_phase;
        end else if (buffer_end_i) begin
          phase_d = wsfd_pkg::PH_HDR1;
        end
      end
      default: phase_d = after_phase;
    endcase
  end

  // result of the current byte
  always_comb begin
    result_o.valid   = 1'b0;
    result_o.data    = '0;
    result_o.status  = wsfd_pkg::ST_DATA;
    result_o.msg_end = 1'b0;
    case (phase_q)
      wsfd_pkg::PH_HDR1: begin
        if (buffer_end_i) begin
          result_o.valid   = 1'b1;
          result_o.status  = wsfd_pkg::ST_SHORT;
          result_o.msg_end = 1'b1;
        end else if ((data_byte_i[3:0] & wsfd_pkg::OPCODE_MASK) != wsfd_pkg::OPCODE_TEXT) begin
          result_o.valid   = 1'b1;
          result_o.status  = wsfd_pkg::ST_OPCODE;
          result_o.msg_end = 1'b1;
        end
      end
      wsfd_pkg::PH_HDR2, wsfd_pkg::PH_EXTLEN: begin
        if (buffer_end_i) begin
          result_o.valid   = 1'b1;
          result_o.status  = wsfd_pkg::ST_SHORT;
          result_o.msg_end = 1'b1;
        end
      end
      wsfd_pkg::PH_KEY: begin
        if (key_bytes_seen_q == wsfd_pkg::KEY_LAST && payload_length_q == '0) begin
          result_o.valid   = 1'b1;
          result_o.status  = wsfd_pkg::ST_EMPTY;
          result_o.msg_end = 1'b1;
        end else if (buffer_end_i) begin
          result_o.valid   = 1'b1;
          result_o.status  = wsfd_pkg::ST_SHORT;
          result_o.msg_end = 1'b1;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        result_o.valid = 1'b1;
        if (remaining_done) begin
          result_o.data    = data_byte_i ^ key_byte;
          result_o.msg_end = 1'b1;
        end else if (buffer_end_i) begin
          result_o.status  = wsfd_pkg::ST_SHORT;
          result_o.msg_end = 1'b1;
        end else begin
          result_o.data = data_byte_i ^ key_byte;
        end
      end
      default: result_o.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= wsfd_pkg::PH_HDR1;
      payload_length_q    <= '0;
      length_bytes_left_q <= '0;
      mask_key_q          <= '0;
      key_bytes_seen_q    <= '0;
      payload_remaining_q <= '0;
      mask_position_q     <= '0;
    end else if (accept_i) begin
      phase_q             <= phase_d;
      payload_length_q    <= payload_length_d;
      length_bytes_left_q <= length_bytes_left_d;
      mask_key_q          <= mask_key_d;
      key_bytes_seen_q    <= key_bytes_seen_d;
      payload_remaining_q <= payload_remaining_d;
      mask_position_q     <= mask_position_d;
    end
  end

  `WSFD_ASSERT_NEXT(a_buffer_end_rearms, accept_i && buffer_end_i, phase_q == wsfd_pkg::PH_HDR1, "buffer end did not return to first header byte")
  `WSFD_ASSERT_NOW(a_payload_nonzero, phase_q == wsfd_pkg::PH_PAYLOAD, payload_remaining_q != '0, "payload phase with nothing remaining")
  `WSFD_ASSERT_NOW(a_status_marks_end, result_o.valid && result_o.status != wsfd_pkg::ST_DATA, result_o.msg_end && result_o.data == '0, "status result without end mark or with data")
  `WSFD_ASSERT_NEXT(a_length_to_key, accept_i && !buffer_end_i && phase_q == wsfd_pkg::PH_EXTLEN && length_bytes_left_q == '0, phase_q == wsfd_pkg::PH_KEY, "extended length did not move on to key")

endmodule

// ===== hdl/websocket_frame_decoder.sv =====
// top level of the websocket frame decoder with its result register
// Receive-side decoder for one masked WebSocket text frame per buffer, fed
// one byte per transfer with buffer_end_i on the final byte of the buffer.
// It reads the two header bytes (only opcode 1 is taken, FIN and the mask bit
// are not looked at), a 16-bit or 64-bit big-endian extended length where the
// 7-bit length says so, and the 4-byte masking key, then hands out each
// payload byte XORed with the key byte that rotates with the byte position,
// message_end_o marking the last one. Status results (empty message,
// unsupported opcode, frame too short) carry message_end_o high and a zero
// payload byte; bytes after the frame are dropped up to the buffer end, and
// the byte with buffer_end_i always leaves the block ready for a new frame.
// Rate: one byte per cycle while the result register is free or drained; each
// byte is a single registered pass through the parser, whose longest path is
// the 64-bit payload counter decrement and zero test. A result waits in the
// output register while the next byte is taken as long as out_ready_i is high
// or the register is empty.
module websocket_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       buffer_end_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic [1:0] status_o,
  output logic       message_end_o
);

  wsfd_pkg::result_t result;

  logic       accept;
  logic       out_valid_q;
  logic [7:0] payload_byte_q;
  logic [1:0] status_q;
  logic       message_end_q;

  // take a byte whenever the result register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  wsfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .result_o     (result)
  );

  // valid flag of the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= result.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded only when a byte produces a result
  always_ff @(posedge clk_i) begin
    if (accept && result.valid) begin
      payload_byte_q <= result.data;
      status_q       <= result.status;
      message_end_q  <= result.msg_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = payload_byte_q;
  assign status_o       = status_q;
  assign message_end_o  = message_end_q;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the websocket frame decoder with its own frame predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // run limit, far above the slowest correct run
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  // how the extended length of a built frame is encoded
  typedef enum int unsigned {
    LEN_SHORT,
    LEN_16,
    LEN_64
  } len_form_e;

  typedef logic [7:0] byte_buf_t[$];

  // one decoded result as the block should hand it out
  typedef struct packed {
    logic [7:0]        payload;
    wsfd_pkg::status_e status;
    logic              msg_end;
  } frame_result_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i  = 8'h00;
  logic       buffer_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] payload_byte_o;
  logic [1:0] status_o;
  logic       message_end_o;

  // idle rates in percent, changed between the random phases
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 70;

  int unsigned bytes_sent  = 0;
  int unsigned error_count = 0;

  // results predicted but not yet seen on the output, oldest first
  frame_result_t results_due[$];

  // predictor state, starting at its reset values
  wsfd_pkg::phase_e hdr_phase      = wsfd_pkg::PH_HDR1;
  logic [63:0]      frame_len      = '0;
  logic [2:0]       len_bytes_left = '0;
  logic [31:0]      unmask_key     = '0;
  logic [1:0]       key_count      = '0;
  logic [63:0]      bytes_left     = '0;
  logic [1:0]       key_pos        = '0;

  websocket_frame_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .buffer_end_i   (buffer_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .status_o       (status_o),
    .message_end_o  (message_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_due(input logic [7:0] payload, input wsfd_pkg::status_e status,
                                  input logic msg_end);
    frame_result_t r;
    r.payload = payload;
    r.status  = status;
    r.msg_end = msg_end;
    results_due.insert(results_due.size(), r);
  endfunction

  // advance the frame parser by one accepted byte and queue what it should emit
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    wsfd_pkg::phase_e after_frame;
    int unsigned      shift;
    logic [7:0]       key_byte;
    after_frame = last ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_SKIP;
    case (hdr_phase)
      wsfd_pkg::PH_HDR1: begin
        if (last) begin
          // a lone first byte is too short whatever its opcode
          add_due(8'h00, wsfd_pkg::ST_SHORT, 1'b1);
          hdr_phase = wsfd_pkg::PH_HDR1;
        end else if ((b[3:0] & wsfd_pkg::OPCODE_MASK) != wsfd_pkg::OPCODE_TEXT) begin
          add_due(8'h00, wsfd_pkg::ST_OPCODE, 1'b1);
          hdr_phase = wsfd_pkg::PH_SKIP;
        end else begin
          hdr_phase = wsfd_pkg::PH_HDR2;
        end
      end
      wsfd_pkg::PH_HDR2: begin
        frame_len  = '0;
        key_count  = '0;
        unmask_key = '0;
        if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
          len_bytes_left = wsfd_pkg::EXT16_LEFT;
          hdr_phase      = wsfd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
          len_bytes_left = wsfd_pkg::EXT64_LEFT;
          hdr_phase      = wsfd_pkg::PH_EXTLEN;
        end else begin
          frame_len = {57'd0, b[6:0]};
          hdr_phase = wsfd_pkg::PH_KEY;
        end
        if (last) begin
          add_due(8'h00, wsfd_pkg::ST_SHORT, 1'b1);
          hdr_phase = wsfd_pkg::PH_HDR1;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        // big-endian length, most significant byte first
        frame_len = {frame_len[55:0], b};
        if (len_bytes_left == 3'd0) begin
          key_count  = '0;
          unmask_key = '0;
          hdr_phase  = wsfd_pkg::PH_KEY;
        end else begin
          len_bytes_left = len_bytes_left - 3'd1;
        end
        if (last) begin
          add_due(8'h00, wsfd_pkg::ST_SHORT, 1'b1);
          hdr_phase = wsfd_pkg::PH_HDR1;
        end
      end
      wsfd_pkg::PH_KEY: begin
        unmask_key = {unmask_key[23:0], b};
        if (key_count == wsfd_pkg::KEY_LAST) begin
          key_count  = '0;
          bytes_left = frame_len;
          key_pos    = '0;
          if (frame_len == 64'd0) begin
            add_due(8'h00, wsfd_pkg::ST_EMPTY, 1'b1);
            hdr_phase = after_frame;
          end else if (last) begin
            add_due(8'h00, wsfd_pkg::ST_SHORT, 1'b1);
            hdr_phase = wsfd_pkg::PH_HDR1;
          end else begin
            hdr_phase = wsfd_pkg::PH_PAYLOAD;
          end
        end else begin
          key_count = key_count + 2'd1;
          if (last) begin
            add_due(8'h00, wsfd_pkg::ST_SHORT, 1'b1);
            hdr_phase = wsfd_pkg::PH_HDR1;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        // key byte 0 sits in the top bits and the position rotates per byte
        shift      = 8 * (3 - int'(key_pos));
        key_byte   = unmask_key[shift +: 8];
        bytes_left = bytes_left - 64'd1;
        key_pos    = key_pos + 2'd1;
        if (bytes_left == 64'd0) begin
          add_due(b ^ key_byte, wsfd_pkg::ST_DATA, 1'b1);
          hdr_phase = after_frame;
        end else if (last) begin
          add_due(8'h00, wsfd_pkg::ST_SHORT, 1'b1);
          hdr_phase = wsfd_pkg::PH_HDR1;
        end else begin
          add_due(b ^ key_byte, wsfd_pkg::ST_DATA, 1'b0);
        end
      end
      default: begin
        // trailing bytes are dropped until the buffer end
        hdr_phase = after_frame;
      end
    endcase
  endfunction

  // both channels watched at the rising edge: predict on each input transfer,
  // then compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) decode_byte(data_byte_i, buffer_end_i);
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result with nothing due: payload_byte %0h status %0d message_end %0b",
                 payload_byte_o, status_o, message_end_o);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (payload_byte_o !== want.payload) begin
            $error("payload_byte: expected %0h, got %0h", want.payload, payload_byte_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (message_end_o !== want.msg_end) begin
            $error("message_end: expected %0b, got %0b", want.msg_end, message_end_o);
            error_count++;
          end
        end
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one byte transfer; called and returning at a falling edge, valid left high
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= value;
    buffer_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // a whole receive buffer, buffer_end on its final byte
  task automatic send_buffer(input byte_buf_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // hold the input off until every predicted result has come out
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // header, length, random key and n_payload random payload bytes
  function automatic byte_buf_t build_frame(input logic [3:0] opcode, input len_form_e form,
                                            input logic [63:0] length,
                                            input int unsigned n_payload);
    byte_buf_t   q;
    logic [6:0]  len7;
    logic [31:0] key;
    key = $urandom;
    q.insert(q.size(), {4'($urandom), opcode});
    case (form)
      LEN_16:  len7 = wsfd_pkg::LEN_EXT16;
      LEN_64:  len7 = wsfd_pkg::LEN_EXT64;
      default: len7 = length[6:0];
    endcase
    q.insert(q.size(), {1'($urandom), len7});
    if (form == LEN_16) begin
      q.insert(q.size(), length[15:8]);
      q.insert(q.size(), length[7:0]);
    end else if (form == LEN_64) begin
      for (int i = 7; i >= 0; i--) q.insert(q.size(), length[8*i +: 8]);
    end
    for (int i = 3; i >= 0; i--) q.insert(q.size(), key[8*i +: 8]);
    repeat (n_payload) q.insert(q.size(), 8'($urandom));
    return q;
  endfunction

  task automatic test_one_byte_buffer();
    // too short even with a text opcode, and also with a wrong one
    send_byte(8'h81, 1'b1);
    send_byte(8'h0A, 1'b1);
  endtask

  task automatic test_bad_opcode();
    // the bytes after a rejected header are dropped
    send_buffer('{8'h80, 8'hFF, 8'h00});
  endtask

  task automatic test_empty_message();
    send_buffer('{8'h81, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  task automatic test_truncated_payload();
    // three bytes announced, buffer ends on the second
    send_buffer('{8'h81, 8'h83, 8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hFF, 8'h00});
  endtask

  task automatic test_truncated_header();
    // 16-bit extended length cut after its first byte
    send_buffer('{8'hF1, 8'hFE, 8'h12});
  endtask

  // random buffers: mostly well-formed text frames with random content, some cut
  // short or followed by junk, some with huge lengths, bad opcodes and noise
  task automatic test_random_buffers(input int unsigned n_bytes);
    byte_buf_t   frame;
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    int unsigned r;
    len_form_e   form;
    logic [63:0] length;
    logic [3:0]  op;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      frame.delete();
      if (pick < 70) begin
        r    = $urandom_range(9);
        form = (r < 6) ? LEN_SHORT : ((r < 9) ? LEN_16 : LEN_64);
        case (form)
          LEN_SHORT: length = ($urandom_range(9) == 0) ? $urandom_range(125)
                                                        : $urandom_range(12);
          LEN_16:    length = ($urandom_range(9) == 0) ? $urandom_range(300)
                                                        : $urandom_range(12);
          default:   length = $urandom_range(12);
        endcase
        frame = build_frame(wsfd_pkg::OPCODE_TEXT, form, length, int'(length));
        if ($urandom_range(4) == 0) begin
          // the buffer ends anywhere from the first header byte to the one before the last
          cut = $urandom_range(frame.size() - 1, 1);
          while (frame.size() > cut) void'(frame.pop_back());
        end else begin
          repeat ($urandom_range(3)) frame.insert(frame.size(), 8'($urandom));
        end
      end else if (pick < 82) begin
        // length with every bit in play, buffer ends after a few payload bytes
        form   = ($urandom_range(1) == 0) ? LEN_16 : LEN_64;
        length = {$urandom, $urandom};
        frame  = build_frame(wsfd_pkg::OPCODE_TEXT, form, length, $urandom_range(6));
      end else if (pick < 92) begin
        do op = 4'($urandom); while (op == wsfd_pkg::OPCODE_TEXT);
        frame.insert(frame.size(), {4'($urandom), op});
        repeat ($urandom_range(4)) frame.insert(frame.size(), 8'($urandom));
      end else begin
        repeat ($urandom_range(6, 1)) frame.insert(frame.size(), 8'($urandom));
      end
      send_buffer(frame);
      if ($urandom_range(19) == 0) pause_until_drained();
    end
    pause_until_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_one_byte_buffer();
    test_bad_opcode();
    test_empty_message();
    test_truncated_payload();
    test_truncated_header();

    // sender rarely idle, receiver mostly stalled
    test_random_buffers(340);
    // sender mostly idle, receiver rarely stalled
    send_idle_pct = 70;
    recv_idle_pct = 9;
    test_random_buffers(330);
    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_buffers(330);

    // wait for any stray result to show up
    repeat (4) @(posedge clk_i);
    if (results_due.size() != 0) begin
      $error("%0d predicted results never arrived", results_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results still due", results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
